// ===== hdl/ecal_pkg.sv =====
// Shared types, constants and functions for the epoch seconds to calendar converter.
// Used by every module of the block; depends on nothing.
package ecal_pkg;

   localparam int STAGES = 8;

   typedef logic [STAGES-1:0] stage_en_type;

   localparam int EPOCH_SECONDS_W = 31;
   localparam int DAYS_W          = 15;
   localparam int SOD_W           = 17;
   localparam int YOFF_W          = 7;
   localparam int DOY_W           = 9;
   localparam int YEAR_W          = 11;
   localparam int MONTH_W         = 4;
   localparam int DAY_W           = 5;
   localparam int HOUR_W          = 5;
   localparam int MINUTE_W        = 6;
   localparam int SECOND_W        = 6;
   localparam int WEEKDAY_W       = 3;

   localparam logic [YEAR_W-1:0]  EPOCH_YEAR    = 11'd1970;
   localparam logic [3:0]         EPOCH_WEEKDAY = 4'd4;
   localparam logic [MONTH_W-1:0] LAST_MONTH    = 4'd12;
   localparam logic [30:0]        SECS_PER_DAY  = 31'd86400;
   localparam logic [16:0]        SECS_PER_HOUR = 17'd3600;
   localparam logic [11:0]        SECS_PER_MIN  = 12'd60;
   localparam logic [14:0]        DAYS_PER_YEAR = 15'd365;
   localparam logic [14:0]        DAYS_PER_WEEK = 15'd7;

   // Rounded-up reciprocals; each shift is wide enough for an exact quotient
   // over the full operand range.
   localparam int DAY_SHIFT  = 34;
   localparam int YEAR_SHIFT = 24;
   localparam int WEEK_SHIFT = 20;
   localparam int HOUR_SHIFT = 24;
   localparam int MIN_SHIFT  = 16;
   localparam int MON_SHIFT  = 16;

   localparam logic [24:0] DAY_RECIP  = 25'((64'd1 << DAY_SHIFT) / 64'd675 + 64'd1);
   localparam logic [15:0] YEAR_RECIP = 16'((64'd1 << YEAR_SHIFT) / 64'd365 + 64'd1);
   localparam logic [17:0] WEEK_RECIP = 18'((64'd1 << WEEK_SHIFT) / 64'd7 + 64'd1);
   localparam logic [16:0] HOUR_RECIP = 17'((64'd1 << HOUR_SHIFT) / 64'd225 + 64'd1);
   localparam logic [12:0] MIN_RECIP  = 13'((64'd1 << MIN_SHIFT) / 64'd15 + 64'd1);
   localparam logic [11:0] MON_RECIP  = 12'((64'd1 << MON_SHIFT) / 64'd31 + 64'd1);

   // Days in the year before the first day of month m, for m from 1 to 13.
   function automatic logic [DOY_W-1:0] days_to_month(input logic leap,
                                                      input logic [MONTH_W-1:0] m);
      logic [DOY_W-1:0] d;
      case (m)
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         4'd13:   d = 9'd365;
         default: d = 9'd0;
      endcase
      if (leap && m > 4'd2) begin
         d = d + 9'd1;
      end
      return d;
   endfunction

endpackage

// ===== hdl/ecal_pipe_ctrl.sv =====
// Valid bits and stage enables for the converter pipeline.
// Depends on ecal_pkg.
module ecal_pipe_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ecal_pkg::stage_en_type en
);
   import ecal_pkg::*;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] prev_valid;
   logic [STAGES:0]   ready;

   always_comb begin
      ready[STAGES] = !rsp_stall;
      for (int k = STAGES - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      prev_valid = {valid_ff[STAGES-2:0], req_valid};
      for (int k = 0; k < STAGES; k++) begin
         valid_in[k] = ready[k] ? prev_valid[k] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign en        = ready[STAGES-1:0];
   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[STAGES-1];

`ifndef NO_ASSERTIONS
   a_free_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled although the output stage is empty");
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ($countones(valid_ff) == STAGES))
      else $error("input stalled with a bubble in the pipeline");
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule

// ===== hdl/ecal_day_split.sv =====
// Splits the second count into whole days and seconds of the day (stages 0 to 2).
// Depends on ecal_pkg.
module ecal_day_split (
   input  logic                                   clock,
   input  ecal_pkg::stage_en_type                 en,
   input  logic [ecal_pkg::EPOCH_SECONDS_W-1:0]   epoch_seconds,
   output logic [ecal_pkg::DAYS_W-1:0]            days,
   output logic [ecal_pkg::SOD_W-1:0]             sod
);
   import ecal_pkg::*;

   logic [EPOCH_SECONDS_W-1:0] t0_ff;
   logic [EPOCH_SECONDS_W-1:0] t1_ff;
   logic [DAYS_W-1:0]          days1_ff;
   logic [DAYS_W-1:0]          days1_in;
   logic [DAYS_W-1:0]          days2_ff;
   logic [SOD_W-1:0]           sod2_ff;
   logic [SOD_W-1:0]           sod2_in;
   logic [48:0]                day_prod;
   logic [30:0]                day_secs;
   logic [30:0]                sod_full;

   always_comb begin
      day_prod = 49'(t0_ff[30:7]) * 49'(DAY_RECIP);
      days1_in = day_prod[DAY_SHIFT +: DAYS_W];
      day_secs = 31'(days1_ff) * SECS_PER_DAY;
      sod_full = t1_ff - day_secs;
      sod2_in  = sod_full[SOD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         t0_ff <= epoch_seconds;
      end
      if (en[1]) begin
         t1_ff    <= t0_ff;
         days1_ff <= days1_in;
      end
      if (en[2]) begin
         days2_ff <= days1_ff;
         sod2_ff  <= sod2_in;
      end
   end

   assign days = days2_ff;
   assign sod  = sod2_ff;

endmodule

// ===== hdl/ecal_time_calc.sv =====
// Hour, minute and second from the seconds of the day (stages 3 to 7).
// Depends on ecal_pkg.
module ecal_time_calc (
   input  logic                             clock,
   input  ecal_pkg::stage_en_type           en,
   input  logic [ecal_pkg::SOD_W-1:0]       sod,
   output logic [ecal_pkg::HOUR_W-1:0]      hour,
   output logic [ecal_pkg::MINUTE_W-1:0]    minute,
   output logic [ecal_pkg::SECOND_W-1:0]    second
);
   import ecal_pkg::*;

   logic [SOD_W-1:0]    sod3_ff;
   logic [HOUR_W-1:0]   hour3_ff, hour3_in, hour4_ff, hour5_ff, hour6_ff, hour7_ff;
   logic [11:0]         rem4_ff, rem4_in, rem5_ff;
   logic [MINUTE_W-1:0] min5_ff, min5_in, min6_ff, min7_ff;
   logic [SECOND_W-1:0] sec6_ff, sec6_in, sec7_ff;
   logic [29:0]         hour_prod;
   logic [16:0]         hour_secs;
   logic [16:0]         rem_full;
   logic [22:0]         min_prod;
   logic [11:0]         min_secs;
   logic [11:0]         sec_full;

   always_comb begin
      hour_prod = 30'(sod[SOD_W-1:4]) * 30'(HOUR_RECIP);
      hour3_in  = hour_prod[HOUR_SHIFT +: HOUR_W];
      hour_secs = 17'(hour3_ff) * SECS_PER_HOUR;
      rem_full  = sod3_ff - hour_secs;
      rem4_in   = rem_full[11:0];
      min_prod  = 23'(rem4_ff[11:2]) * 23'(MIN_RECIP);
      min5_in   = min_prod[MIN_SHIFT +: MINUTE_W];
      min_secs  = 12'(min5_ff) * SECS_PER_MIN;
      sec_full  = rem5_ff - min_secs;
      sec6_in   = sec_full[SECOND_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         sod3_ff  <= sod;
         hour3_ff <= hour3_in;
      end
      if (en[4]) begin
         rem4_ff  <= rem4_in;
         hour4_ff <= hour3_ff;
      end
      if (en[5]) begin
         rem5_ff  <= rem4_ff;
         min5_ff  <= min5_in;
         hour5_ff <= hour4_ff;
      end
      if (en[6]) begin
         sec6_ff  <= sec6_in;
         min6_ff  <= min5_ff;
         hour6_ff <= hour5_ff;
      end
      if (en[7]) begin
         sec7_ff  <= sec6_ff;
         min7_ff  <= min6_ff;
         hour7_ff <= hour6_ff;
      end
   end

   assign hour   = hour7_ff;
   assign minute = min7_ff;
   assign second = sec7_ff;

endmodule

// ===== hdl/ecal_date_calc.sv =====
// Year, month, day of month and weekday from the whole day count (stages 3 to 7).
// Depends on ecal_pkg.
module ecal_date_calc (
   input  logic                             clock,
   input  ecal_pkg::stage_en_type           en,
   input  logic                             out_valid,
   input  logic [ecal_pkg::DAYS_W-1:0]      days,
   output logic [ecal_pkg::YEAR_W-1:0]      year,
   output logic [ecal_pkg::MONTH_W-1:0]     month,
   output logic [ecal_pkg::DAY_W-1:0]       day,
   output logic [ecal_pkg::WEEKDAY_W-1:0]   weekday
);
   import ecal_pkg::*;

   logic [DAYS_W-1:0]    days3_ff, days4_ff;
   logic [YOFF_W-1:0]    yoff3_ff, yoff3_in, yoff4_ff, yoff5_ff, yoff5_in;
   logic [11:0]          week3_ff, week3_in;
   logic [DAYS_W-1:0]    dty0_ff, dty0_in, dty1_ff, dty1_in;
   logic [WEEKDAY_W-1:0] wd4_ff, wd4_in, wd5_ff, wd6_ff, wd7_ff;
   logic [DOY_W-1:0]     doy5_ff, doy5_in, doy6_ff;
   logic                 leap5_ff, leap5_in, leap6_ff;
   logic [YEAR_W-1:0]    year6_ff, year7_ff;
   logic [MONTH_W-1:0]   mon6_ff, mon6_in, mon7_ff, mon7_in;
   logic [DAY_W-1:0]     dom7_ff, dom7_in;
   logic [30:0]          year_prod;
   logic [DAYS_W-1:0]    days_plus;
   logic [32:0]          week_prod;
   logic [DAYS_W-1:0]    week_days;
   logic [DAYS_W-1:0]    wd_full;
   logic [DAYS_W-1:0]    doy_full;
   logic [20:0]          mon_prod;
   logic [MONTH_W-1:0]   mon_est;
   logic [MONTH_W-1:0]   mon_next;
   logic                 bump;
   logic [DOY_W-1:0]     dom_full;

   always_comb begin
      year_prod = 31'(days) * 31'(YEAR_RECIP);
      yoff3_in  = year_prod[YEAR_SHIFT +: YOFF_W];
      days_plus = days + DAYS_W'(EPOCH_WEEKDAY);
      week_prod = 33'(days_plus) * 33'(WEEK_RECIP);
      week3_in  = week_prod[WEEK_SHIFT +: 12];

      // Within 1970 to 2038 every fourth year from 1972 is a leap year.
      dty0_in   = DAYS_W'(yoff3_ff) * DAYS_PER_YEAR
                  + DAYS_W'((8'(yoff3_ff) + 8'd1) >> 2);
      dty1_in   = DAYS_W'(yoff3_ff - YOFF_W'(1)) * DAYS_PER_YEAR
                  + DAYS_W'(yoff3_ff >> 2);
      week_days = DAYS_W'(week3_ff) * DAYS_PER_WEEK;
      wd_full   = days3_ff + DAYS_W'(EPOCH_WEEKDAY) - week_days;
      wd4_in    = wd_full[WEEKDAY_W-1:0];

      if (days4_ff < dty0_ff) begin
         yoff5_in = yoff4_ff - YOFF_W'(1);
         doy_full = days4_ff - dty1_ff;
      end else begin
         yoff5_in = yoff4_ff;
         doy_full = days4_ff - dty0_ff;
      end
      doy5_in  = doy_full[DOY_W-1:0];
      leap5_in = (yoff5_in[1:0] == 2'd2);

      mon_prod = 21'(doy5_ff) * 21'(MON_RECIP);
      mon_est  = mon_prod[MON_SHIFT +: MONTH_W] + MONTH_W'(1);
      mon6_in  = (mon_est > LAST_MONTH) ? LAST_MONTH : mon_est;

      mon_next = mon6_ff + MONTH_W'(1);
      bump     = (doy6_ff >= days_to_month(leap6_ff, mon_next)) && (mon6_ff < LAST_MONTH);
      mon7_in  = bump ? mon_next : mon6_ff;
      dom_full = doy6_ff - days_to_month(leap6_ff, mon7_in) + DOY_W'(1);
      dom7_in  = dom_full[DAY_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         days3_ff <= days;
         yoff3_ff <= yoff3_in;
         week3_ff <= week3_in;
      end
      if (en[4]) begin
         days4_ff <= days3_ff;
         yoff4_ff <= yoff3_ff;
         dty0_ff  <= dty0_in;
         dty1_ff  <= dty1_in;
         wd4_ff   <= wd4_in;
      end
      if (en[5]) begin
         yoff5_ff <= yoff5_in;
         doy5_ff  <= doy5_in;
         leap5_ff <= leap5_in;
         wd5_ff   <= wd4_ff;
      end
      if (en[6]) begin
         year6_ff <= EPOCH_YEAR + YEAR_W'(yoff5_ff);
         doy6_ff  <= doy5_ff;
         leap6_ff <= leap5_ff;
         mon6_ff  <= mon6_in;
         wd6_ff   <= wd5_ff;
      end
      if (en[7]) begin
         year7_ff <= year6_ff;
         mon7_ff  <= mon7_in;
         dom7_ff  <= dom7_in;
         wd7_ff   <= wd6_ff;
      end
   end

   assign year    = year7_ff;
   assign month   = mon7_ff;
   assign day     = dom7_ff;
   assign weekday = wd7_ff;

`ifndef NO_ASSERTIONS
   a_month_range: assert property (@(posedge clock)
      out_valid |-> (mon7_ff >= 4'd1 && mon7_ff <= LAST_MONTH))
      else $error("month out of range");
   a_day_range: assert property (@(posedge clock)
      out_valid |-> (dom7_ff >= 5'd1))
      else $error("day of month is zero");
   a_weekday_range: assert property (@(posedge clock)
      out_valid |-> (wd7_ff <= 3'd6))
      else $error("weekday out of range");
`endif

endmodule

// ===== hdl/epoch_seconds_to_calendar.sv =====
// Top level of the epoch seconds to Gregorian calendar converter.
// Depends on ecal_pkg, ecal_pipe_ctrl, ecal_day_split, ecal_time_calc and ecal_date_calc.
//
//   channel   direction   handshake                 payload
//   req       in          req_valid / req_stall     req_epoch_seconds
//   rsp       out         rsp_valid / rsp_stall     rsp_year .. rsp_weekday
//
// An item passes eight pipeline stages, stage 0 to stage 7; its result is valid once it
// reaches stage 7. Unless req_stall is high, one item can be accepted every cycle;
// constant divisions use reciprocal multipliers.
// Reset is synchronous and clears only the stage valid bits.
// A stalled result holds the unbroken run of full stages behind it; empty stages fill.
module epoch_seconds_to_calendar (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [ecal_pkg::EPOCH_SECONDS_W-1:0]  req_epoch_seconds,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [ecal_pkg::YEAR_W-1:0]           rsp_year,
   output logic [ecal_pkg::MONTH_W-1:0]          rsp_month,
   output logic [ecal_pkg::DAY_W-1:0]            rsp_day,
   output logic [ecal_pkg::HOUR_W-1:0]           rsp_hour,
   output logic [ecal_pkg::MINUTE_W-1:0]         rsp_minute,
   output logic [ecal_pkg::SECOND_W-1:0]         rsp_second,
   output logic [ecal_pkg::WEEKDAY_W-1:0]        rsp_weekday
);
   import ecal_pkg::*;

   stage_en_type      en;
   logic [DAYS_W-1:0] days;
   logic [SOD_W-1:0]  sod;

   ecal_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .en        (en)
   );

   ecal_day_split u_split (
      .clock         (clock),
      .en            (en),
      .epoch_seconds (req_epoch_seconds),
      .days          (days),
      .sod           (sod)
   );

   ecal_time_calc u_time (
      .clock  (clock),
      .en     (en),
      .sod    (sod),
      .hour   (rsp_hour),
      .minute (rsp_minute),
      .second (rsp_second)
   );

   ecal_date_calc u_date (
      .clock     (clock),
      .en        (en),
      .out_valid (rsp_valid),
      .days      (days),
      .year      (rsp_year),
      .month     (rsp_month),
      .day       (rsp_day),
      .weekday   (rsp_weekday)
   );

endmodule
